// ----- rtl/rsi_pkg.sv -----
// ----------------------------------------------------------------------------
// rsi_pkg - shared types for the stretch increment block
// Request and response bundles of the shared multiply-divide unit.
// ----------------------------------------------------------------------------
package rsi_pkg;

	localparam int unsigned MulAW  = 48;  // magnitude operand
	localparam int unsigned MulBW  = 16;  // scale operand, MSB first
	localparam int unsigned DivW   = 18;  // divisor and addend
	localparam int unsigned QuotW  = 64;  // product and quotient

	// request to the shared unit: quot = (mul_a * mul_b + add_c) / div_d
	typedef struct packed {
		logic               start;
		logic [MulAW-1:0]   mul_a;
		logic [MulBW-1:0]   mul_b;
		logic [DivW-1:0]    add_c;
		logic [DivW-1:0]    div_d;
	} rsi_req_t;

	// response: done pulses for one cycle with the quotient valid
	typedef struct packed {
		logic               done;
		logic [QuotW-1:0]   quot;
	} rsi_rsp_t;

endpackage

// ----- rtl/rsi_muldiv.sv -----
// ----------------------------------------------------------------------------
// rsi_muldiv - serial multiply, add and divide unit
// One shared 64-bit adder does a 16-step shift-add multiply, one addend step
// and a 64-step restoring division, one bit per cycle.
// ----------------------------------------------------------------------------
module rsi_muldiv (
	input  logic              clk,
	input  logic              arst_n,
	input  rsi_pkg::rsi_req_t req,
	output rsi_pkg::rsi_rsp_t rsp
);
	import rsi_pkg::*;

	localparam int unsigned MulSteps = MulBW;
	localparam int unsigned DivSteps = QuotW;
	localparam int unsigned CntW     = $clog2(DivSteps);

	typedef enum logic [1:0] {
		U_IDLE,
		U_MUL,
		U_ADDC,
		U_DIV
	} ustate_t;

	ustate_t            state_q;
	logic [CntW-1:0]    cnt_q;
	logic [MulAW-1:0]   a_q;
	logic [MulBW-1:0]   b_q;
	logic [DivW-1:0]    c_q;
	logic [DivW-1:0]    d_q;
	logic [QuotW-1:0]   acc_q;
	logic [DivW-1:0]    rem_q;
	logic               done_q;

	logic [DivW:0]      trial;
	logic [QuotW-1:0]   op_x;
	logic [QuotW-1:0]   op_y;
	logic               cin;
	logic [QuotW-1:0]   sum;
	logic               fits;

	// select operands of the shared adder
	assign trial = {rem_q, acc_q[QuotW-1]};

	always_comb begin
		op_x = '0;
		op_y = '0;
		cin  = 1'b0;
		unique case (state_q)
			U_MUL: begin
				op_x = {acc_q[QuotW-2:0], 1'b0};
				op_y = b_q[MulBW-1] ? QuotW'(a_q) : '0;
			end
			U_ADDC: begin
				op_x = acc_q;
				op_y = QuotW'(c_q);
			end
			U_DIV: begin
				op_x = QuotW'(trial);
				op_y = ~QuotW'(d_q);
				cin  = 1'b1;
			end
			default: begin
				op_x = '0;
			end
		endcase
	end

	assign sum  = op_x + op_y + QuotW'(cin);
	assign fits = ~sum[QuotW-1];

	// sequence the multiply, addend and divide steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			cnt_q   <= '0;
			a_q     <= '0;
			b_q     <= '0;
			c_q     <= '0;
			d_q     <= '0;
			acc_q   <= '0;
			rem_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				U_IDLE: begin
					if (req.start) begin
						a_q     <= req.mul_a;
						b_q     <= req.mul_b;
						c_q     <= req.add_c;
						d_q     <= req.div_d;
						acc_q   <= '0;
						cnt_q   <= CntW'(MulSteps - 1);
						state_q <= U_MUL;
					end
				end
				U_MUL: begin
					acc_q <= sum;
					b_q   <= {b_q[MulBW-2:0], 1'b0};
					if (cnt_q == '0) begin
						state_q <= U_ADDC;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				U_ADDC: begin
					acc_q   <= sum;
					rem_q   <= '0;
					cnt_q   <= CntW'(DivSteps - 1);
					state_q <= U_DIV;
				end
				U_DIV: begin
					rem_q <= fits ? sum[DivW-1:0] : trial[DivW-1:0];
					acc_q <= {acc_q[QuotW-2:0], fits};
					if (cnt_q == '0) begin
						done_q  <= 1'b1;
						state_q <= U_IDLE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: begin
					state_q <= U_IDLE;
				end
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = acc_q;

	// a request only arrives while the unit is free
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> state_q == U_IDLE)
		else $error("muldiv request while busy");

	// the remainder stays below the divisor throughout the division
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == U_DIV |-> rem_q < d_q)
		else $error("division remainder out of range");

	// completion is a single-cycle pulse
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.done)
		else $error("done held longer than one cycle");

endmodule

// ----- rtl/realtime_stretch_increment.sv -----
// ----------------------------------------------------------------------------
// realtime_stretch_increment - hop increment calculator for a time stretcher
// Decides transients and phase resets per hop and returns the output hop.
// ----------------------------------------------------------------------------
// One request is taken at a time. A clear command goes straight from idle
// to the output state. A normal hop steps through the product, branch, round,
// clamp, update and output states, with one pass through the shared
// multiply-divide unit when the ratio changed and one when the divergence
// changes sign. A transient hop makes two passes (amnesty count, then
// recovery). The serial divider produces one of 64 quotient bits per cycle.
// A finished answer waits in the output register while the next request is
// taken; the sequencer only stalls if that answer is still untaken when the
// next one is ready.
module realtime_stretch_increment (
	input  logic        clk,
	input  logic        arst_n,
	// input requests
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // stretch_ratio[19:0], detect_value[35:20],
	                               // hop_increment[47:36]
	input  logic        s_tuser,   // command[0]
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // output_increment[17:0], zero fill[23:18]
	output logic        m_tuser,   // transient_flag[0]
	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [17:0] cfg_data
);
	import rsi_pkg::*;

	localparam logic [1:0] CfgSampleRate = 2'd0;
	localparam logic [1:0] CfgDefaultInc = 2'd1;
	localparam logic [1:0] CfgHardPeaks  = 2'd2;

	localparam logic       CmdClear      = 1'b1;

	localparam logic signed [47:0] Max48 = {1'b0, {47{1'b1}}};
	localparam logic signed [47:0] Min48 = {1'b1, {47{1'b0}}};

	typedef enum logic [3:0] {
		S_IDLE,
		S_PROD,
		S_BRANCH,
		S_AMN_GO,
		S_AMN_WAIT,
		S_REC_GO,
		S_REC_WAIT,
		S_ROUND,
		S_CLAMP,
		S_UPD,
		S_OUT
	} state_t;

	function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
		logic signed [47:0] r;
		if (v[49] && !(&v[48:47])) begin
			r = Min48;
		end else if (!v[49] && (|v[48:47])) begin
			r = Max48;
		end else begin
			r = v[47:0];
		end
		return r;
	endfunction

	// configuration
	logic [17:0]        rate_q;
	logic [11:0]        def_inc_q;
	logic               hpe_q;

	// sequencer and block state
	state_t             state_q;
	logic               cmd_in;
	logic [19:0]        ratio_in;
	logic [15:0]        detect_in;
	logic [11:0]        hop_in;
	logic [11:0]        inc_in;
	logic [19:0]        ratio_q;
	logic [15:0]        detect_q;
	logic [11:0]        inc_q;
	logic [31:0]        t_q;
	logic               trans_q;
	logic               ratio_chg_q;
	logic               rec_last_q;
	logic               rec_neg_q;
	logic [15:0]        prev_detect_q;
	logic [19:0]        prev_ratio_q;
	logic [15:0]        amnesty_q;
	logic signed [47:0] div_q;
	logic signed [47:0] rec_q;
	logic signed [34:0] incr_q;
	logic signed [17:0] hop_q;
	logic signed [17:0] pend_inc_q;
	logic               pend_flag_q;
	logic               m_tvalid_q;
	logic signed [17:0] out_inc_q;
	logic               out_flag_q;

	// combinational helpers
	logic [17:0]        rate_eff;
	logic [16:0]        inc20;
	logic [15:0]        inc10;
	logic [47:0]        div_mag;
	logic [19:0]        det_x10;
	logic [19:0]        prev_x11;
	logic [20:0]        det_x20;
	logic signed [49:0] div_trans;
	logic signed [49:0] div_norm;
	logic signed [47:0] div_next;
	logic signed [50:0] x_round;
	logic [32:0]        lo_sum;
	logic [33:0]        hi_sum;
	logic signed [34:0] lo_ext;
	logic signed [34:0] hi_ext;
	logic [47:0]        rec_pos;
	logic signed [47:0] rec_sat;
	rsi_req_t           req;
	rsi_rsp_t           rsp;

	// unpack the request
	assign cmd_in    = s_tuser;
	assign ratio_in  = s_tdata[19:0];
	assign detect_in = s_tdata[35:20];
	assign hop_in    = s_tdata[47:36];
	assign inc_in    = (hop_in != '0) ? hop_in :
	                   (def_inc_q != '0) ? def_inc_q : 12'd1;

	assign rate_eff  = (rate_q != '0) ? rate_q : 18'd1;
	assign inc20     = 17'(inc_q) * 17'd20;
	assign inc10     = 16'(inc_q) * 16'd10;
	assign div_mag   = div_q[47] ? 48'(48'd0 - div_q) : div_q;

	// transient test terms
	assign det_x10   = 20'(detect_q) * 20'd10;
	assign prev_x11  = 20'(prev_detect_q) * 20'd11;
	assign det_x20   = 21'(detect_q) * 21'd20;

	// divergence updates for the two kinds of hop
	assign div_trans = {{2{div_q[47]}}, div_q} + $signed({22'd0, inc_q, 16'd0})
	                 - $signed({18'd0, t_q});
	assign div_norm  = {{2{div_q[47]}}, div_q} - $signed({18'd0, t_q})
	                 + $signed({{16{hop_q[17]}}, hop_q, 16'd0});
	assign div_next  = sat48(div_norm);

	// rounding and clamp bounds
	assign x_round   = $signed({19'd0, t_q}) - $signed({{3{rec_q[47]}}, rec_q})
	                 + 51'sd32768;
	assign lo_sum    = 33'(t_q) + 33'd65536;
	assign hi_sum    = {2'b00, t_q[31:0]} + {2'b00, t_q[31:0]} + 34'd32768;
	assign lo_ext    = $signed({19'd0, lo_sum[32:17]});
	assign hi_ext    = $signed({17'd0, hi_sum[33:16]});

	// saturate the quotient into a signed recovery rate
	assign rec_pos   = (|rsp.quot[63:47]) ? 48'(Max48) : rsp.quot[47:0];
	assign rec_sat   = !rec_neg_q ? $signed(rec_pos) :
	                   ((|rsp.quot[63:48]) || (rsp.quot[47] && (|rsp.quot[46:0]))) ?
	                   Min48 : $signed(48'(48'd0 - rsp.quot[47:0]));

	// drive requests to the shared unit
	always_comb begin
		req.start = 1'b0;
		req.mul_a = '0;
		req.mul_b = '0;
		req.add_c = '0;
		req.div_d = '0;
		unique case (state_q)
			S_AMN_GO: begin
				req.start = 1'b1;
				req.mul_a = 48'(rate_eff) + 48'(inc20) - 48'd1;
				req.mul_b = 16'd1;
				req.div_d = 18'(inc20);
			end
			S_REC_GO: begin
				req.start = 1'b1;
				req.mul_a = div_mag;
				req.mul_b = inc10;
				req.add_c = {1'b0, rate_eff[17:1]};
				req.div_d = rate_eff;
			end
			default: begin
				req.start = 1'b0;
			end
		endcase
	end

	rsi_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// take register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q    <= 18'd44100;
			def_inc_q <= 12'd256;
			hpe_q     <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CfgSampleRate: rate_q    <= cfg_data;
				CfgDefaultInc: def_inc_q <= cfg_data[11:0];
				CfgHardPeaks:  hpe_q     <= cfg_data[0];
				default:       ;
			endcase
		end
	end

	// sequence one hop and hold the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			ratio_q       <= '0;
			detect_q      <= '0;
			inc_q         <= '0;
			t_q           <= '0;
			trans_q       <= 1'b0;
			ratio_chg_q   <= 1'b0;
			rec_last_q    <= 1'b0;
			rec_neg_q     <= 1'b0;
			prev_detect_q <= '0;
			prev_ratio_q  <= 20'd65536;
			amnesty_q     <= '0;
			div_q         <= '0;
			rec_q         <= '0;
			incr_q        <= '0;
			hop_q         <= '0;
			pend_inc_q    <= '0;
			pend_flag_q   <= 1'b0;
			m_tvalid_q    <= 1'b0;
			out_inc_q     <= '0;
			out_flag_q    <= 1'b0;
		end else begin
			// drop a taken result; the output state reloads it on its own
			if (m_tvalid_q && m_tready && state_q != S_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						if (cmd_in == CmdClear) begin
							prev_detect_q <= '0;
							div_q         <= '0;
							pend_inc_q    <= '0;
							pend_flag_q   <= 1'b0;
							state_q       <= S_OUT;
						end else begin
							ratio_q  <= ratio_in;
							detect_q <= detect_in;
							inc_q    <= inc_in;
							state_q  <= S_PROD;
						end
					end
				end
				S_PROD: begin
					t_q           <= 32'(inc_q) * 32'(ratio_q);
					trans_q       <= hpe_q && (det_x10 > prev_x11) &&
					                 (det_x20 > 21'd28672) && (amnesty_q == '0);
					ratio_chg_q   <= ratio_q != prev_ratio_q;
					prev_detect_q <= detect_q;
					prev_ratio_q  <= ratio_q;
					state_q       <= S_BRANCH;
				end
				S_BRANCH: begin
					if (trans_q) begin
						div_q       <= sat48(div_trans);
						pend_inc_q  <= 18'sd0 - $signed({6'd0, inc_q});
						pend_flag_q <= 1'b1;
						state_q     <= S_AMN_GO;
					end else begin
						if (amnesty_q != '0) begin
							amnesty_q <= amnesty_q - 1'b1;
						end
						rec_last_q <= 1'b0;
						state_q    <= ratio_chg_q ? S_REC_GO : S_ROUND;
					end
				end
				S_AMN_GO: begin
					state_q <= S_AMN_WAIT;
				end
				S_AMN_WAIT: begin
					if (rsp.done) begin
						amnesty_q  <= rsp.quot[15:0];
						rec_last_q <= 1'b1;
						state_q    <= S_REC_GO;
					end
				end
				S_REC_GO: begin
					rec_neg_q <= div_q[47];
					state_q   <= S_REC_WAIT;
				end
				S_REC_WAIT: begin
					if (rsp.done) begin
						rec_q   <= rec_sat;
						state_q <= rec_last_q ? S_OUT : S_ROUND;
					end
				end
				S_ROUND: begin
					incr_q  <= x_round[50:16];
					state_q <= S_CLAMP;
				end
				S_CLAMP: begin
					if (incr_q < lo_ext) begin
						hop_q <= lo_ext[17:0];
					end else if (incr_q > hi_ext) begin
						hop_q <= hi_ext[17:0];
					end else begin
						hop_q <= incr_q[17:0];
					end
					state_q <= S_UPD;
				end
				S_UPD: begin
					div_q       <= div_next;
					pend_inc_q  <= hop_q;
					pend_flag_q <= 1'b0;
					rec_last_q  <= 1'b1;
					if ((div_q < 0 && div_next > 0) || (div_q > 0 && div_next < 0)) begin
						state_q <= S_REC_GO;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						out_inc_q  <= pend_inc_q;
						out_flag_q <= pend_flag_q;
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {6'd0, out_inc_q};
	assign m_tuser   = out_flag_q;

	// the shared unit only completes while the sequencer waits for it
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> (state_q == S_AMN_WAIT || state_q == S_REC_WAIT))
		else $error("muldiv completion outside a wait state");

	// an accepted request makes the block busy
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while busy");

	// a transient answer is always a negative hop
	a_trans_negative: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[17])
		else $error("transient answer is not negative");

endmodule
